### rtl/ump_pkg.sv
// Shared types, constants and the log-fraction table function for the
// urban macro path loss pipeline. No dependencies.
`default_nettype none
package ump_pkg;

  localparam int LOG_TABLE_ENTRIES_DEF = 256;

  localparam int HGT_W      = 12;
  localparam int DIST_W     = 20;
  localparam int WL_W       = 16;
  localparam int CAR_W      = 14;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int LOG_W      = 24;
  localparam int INR_W      = 26;
  localparam int ACC_W      = 48;

  localparam logic [CFG_IDX_W-1:0] REG_ENV_HEIGHT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAVELENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_MHZ  = 2'd3;

  localparam logic [HGT_W-1:0]  RST_ENV_HEIGHT   = 12'd0;
  localparam logic [WL_W-1:0]   RST_WAVELENGTH   = 16'd3330;
  localparam logic [DIST_W-1:0] RST_MIN_DISTANCE = 20'd16;
  localparam logic [CAR_W-1:0]  RST_CARRIER_MHZ  = 14'd5900;

  localparam logic FUNC_LOS  = 1'b0;
  localparam logic FUNC_NLOS = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BELOW_MIN = 2'd1;
  localparam logic [1:0] STATUS_BAD_ARG   = 2'd2;

  localparam logic signed [16:0] LOSS_MAX = 17'sd65535;
  localparam logic signed [16:0] LOSS_MIN = -17'sd65535 - 17'sd1;

  localparam logic signed [LOG_W-1:0] LOG10_2    = 24'sd19728;
  localparam logic signed [LOG_W-1:0] LOG10_5000 = 24'sd242416;

  localparam logic signed [ACC_W-1:0] C26   = 48'sd6656;
  localparam logic signed [ACC_W-1:0] C39   = 48'sd9984;
  localparam logic signed [ACC_W-1:0] C20   = 48'sd5120;
  localparam logic signed [ACC_W-1:0] C40   = 48'sd10240;
  localparam logic signed [ACC_W-1:0] C1347 = 48'sd3448;
  localparam logic signed [ACC_W-1:0] C14   = 48'sd3584;
  localparam logic signed [ACC_W-1:0] C6    = 48'sd1536;
  localparam logic signed [ACC_W-1:0] C449  = 48'sd11494;
  localparam logic signed [ACC_W-1:0] C655  = 48'sd1677;
  localparam logic signed [ACC_W-1:0] C3446 = 48'sd8822;
  localparam logic signed [ACC_W-1:0] C583  = 48'sd1492;
  localparam logic signed [ACC_W-1:0] C23   = 48'sd5888;

  typedef struct packed {
    logic              func;
    logic [HGT_W-1:0]  tx_height;
    logic [HGT_W-1:0]  rx_height;
    logic [DIST_W-1:0] distance;
  } req_t;

  typedef struct packed {
    logic signed [16:0] loss_db;
    logic [1:0]         status;
  } rsp_t;

  typedef struct packed {
    logic                    func;
    logic                    below;
    logic [HGT_W-1:0]        tx;
    logic signed [HGT_W:0]   ht;
    logic signed [HGT_W:0]   hr;
    logic [DIST_W-1:0]       span;
    logic [DIST_W+WL_W-1:0]  dwl;
    logic signed [2*HGT_W+1:0] hh;
  } front_t;

  typedef struct packed {
    logic func;
    logic below;
    logic invalid;
    logic near;
  } side_t;

  // log2(1 + i/N) in Q16 by repeated squaring of the Q30 argument
  function automatic logic [16:0] log_frac(input logic [63:0] x0);
    logic [63:0] x;
    logic [16:0] bits;
    logic [17:0] r;
    x = x0;
    bits = '0;
    for (int k = 0; k < 17; k++) begin
      x = (x * x) >> 30;
      bits = {bits[15:0], 1'b0};
      if (x >= 64'h8000_0000) begin
        bits[0] = 1'b1;
        x = x >> 1;
      end
    end
    r = {1'b0, bits} + 18'd1;
    return r[17:1];
  endfunction

endpackage
`default_nettype wire

### rtl/urban_macro_path_loss_core.sv
// Urban macro path loss core: top level with config registers and pipeline control.
// Depends on ump_pkg, ump_front, ump_log10, ump_combine.
//
// One link per request on req (valid/ready), one result per request on rsp
// (valid/ready): loss_db in 1/256 dB, saturated, and a status code.
// Config registers are written through cfg_we/cfg_index/cfg_data with no
// wait; write them only while no request is in flight.
// Seven register stages: capture and products, leading one, log table,
// log scale, law sums, NLOS slope product, round and saturate.
// rsp_valid is the valid of the last stage; throughput is one request per
// cycle while rsp is not stalled, set by the fully pipelined log units.
// Each stage holds its item while the next is full and held, so a stall on rsp
// backs up stage by stage; req_ready drops only once all seven are full.
// Synchronous reset clears all stage valids and loads the config defaults
// (env height 0, wavelength 3330, min distance 16, carrier 5900 MHz).
`default_nettype none
module urban_macro_path_loss_core #(
  parameter int LOG_TABLE_ENTRIES = ump_pkg::LOG_TABLE_ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_ready,
  input  wire ump_pkg::req_t                     req,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_ready,
  output ump_pkg::rsp_t                          rsp,
  input  wire logic                              cfg_we,
  input  wire logic [ump_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ump_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int NS = 7;

  logic [ump_pkg::HGT_W-1:0]  env_height;
  logic [ump_pkg::WL_W-1:0]   wavelength;
  logic [ump_pkg::DIST_W-1:0] min_distance;
  logic [ump_pkg::CAR_W-1:0]  carrier_mhz;

  always_ff @(posedge clk) begin
    if (rst) begin
      env_height   <= ump_pkg::RST_ENV_HEIGHT;
      wavelength   <= ump_pkg::RST_WAVELENGTH;
      min_distance <= ump_pkg::RST_MIN_DISTANCE;
      carrier_mhz  <= ump_pkg::RST_CARRIER_MHZ;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ump_pkg::REG_ENV_HEIGHT:   env_height   <= cfg_data[ump_pkg::HGT_W-1:0];
        ump_pkg::REG_WAVELENGTH:   wavelength   <= cfg_data[ump_pkg::WL_W-1:0];
        ump_pkg::REG_MIN_DISTANCE: min_distance <= cfg_data[ump_pkg::DIST_W-1:0];
        ump_pkg::REG_CARRIER_MHZ:  carrier_mhz  <= cfg_data[ump_pkg::CAR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v[NS-1] || rsp_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= req_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  assign req_ready = en[0];
  assign rsp_valid = v[NS-1];

  ump_pkg::front_t fq;

  ump_front u_front (
    .clk          (clk),
    .en           (en[0]),
    .req          (req),
    .env_height   (env_height),
    .wavelength   (wavelength),
    .min_distance (min_distance),
    .q            (fq)
  );

  logic signed [ump_pkg::DIST_W+ump_pkg::WL_W+4:0] lhs, rhs;
  logic                                            near, bad_los, bad_nlos, zero_arg;
  ump_pkg::side_t side_next, side_s2, side_s3, side_s4;
  logic [ump_pkg::HGT_W-1:0] h1_arg;

  always_comb begin
    lhs      = $signed({5'b0, fq.dwl});
    rhs      = (ump_pkg::DIST_W + ump_pkg::WL_W + 5)'(fq.hh) <<< 14;
    near     = lhs < rhs;
    zero_arg = (fq.span == '0) || (carrier_mhz == '0);
    bad_los  = zero_arg || (!near && ((fq.ht <= 0) || (fq.hr <= 0)));
    bad_nlos = zero_arg || (fq.tx == '0);
    side_next.func    = fq.func;
    side_next.below   = fq.below;
    side_next.near    = near;
    side_next.invalid = (fq.func == ump_pkg::FUNC_NLOS) ? bad_nlos : bad_los;
    h1_arg = (fq.func == ump_pkg::FUNC_NLOS) ? fq.tx : fq.ht[ump_pkg::HGT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) side_s2 <= side_next;
    if (en[2]) side_s3 <= side_s2;
    if (en[3]) side_s4 <= side_s3;
  end

  logic signed [ump_pkg::LOG_W-1:0] ld, lf, lh1, lh2;

  ump_log10 #(.N(LOG_TABLE_ENTRIES), .W(ump_pkg::DIST_W), .SHIFT(4)) u_log_d (
    .clk (clk), .en (en[3:1]), .arg (fq.span), .lg (ld)
  );

  ump_log10 #(.N(LOG_TABLE_ENTRIES), .W(ump_pkg::CAR_W), .SHIFT(0)) u_log_f (
    .clk (clk), .en (en[3:1]), .arg (carrier_mhz), .lg (lf)
  );

  ump_log10 #(.N(LOG_TABLE_ENTRIES), .W(ump_pkg::HGT_W), .SHIFT(4)) u_log_h1 (
    .clk (clk), .en (en[3:1]), .arg (h1_arg), .lg (lh1)
  );

  ump_log10 #(.N(LOG_TABLE_ENTRIES), .W(ump_pkg::HGT_W), .SHIFT(4)) u_log_h2 (
    .clk (clk), .en (en[3:1]), .arg (fq.hr[ump_pkg::HGT_W-1:0]), .lg (lh2)
  );

  ump_combine u_combine (
    .clk  (clk),
    .en   (en[6:4]),
    .side (side_s4),
    .ld   (ld),
    .lf   (lf),
    .lh1  (lh1),
    .lh2  (lh2),
    .rsp  (rsp)
  );

  a_below_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ump_pkg::STATUS_BELOW_MIN |-> rsp.loss_db == '0)
    else $error("below-minimum result with nonzero loss");

  a_bad_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ump_pkg::STATUS_BAD_ARG |-> rsp.loss_db == ump_pkg::LOSS_MAX)
    else $error("invalid-argument result not saturated");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request stalled while pipeline can drain");

endmodule
`default_nettype wire

### rtl/ump_front.sv
// First pipeline stage: input capture, effective heights and breakpoint products.
// Depends on ump_pkg.
`default_nettype none
module ump_front (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire ump_pkg::req_t                 req,
  input  wire logic [ump_pkg::HGT_W-1:0]     env_height,
  input  wire logic [ump_pkg::WL_W-1:0]      wavelength,
  input  wire logic [ump_pkg::DIST_W-1:0]    min_distance,
  output ump_pkg::front_t                    q
);

  ump_pkg::front_t q_next;

  always_comb begin
    q_next.func  = req.func;
    q_next.tx    = req.tx_height;
    q_next.span  = req.distance;
    q_next.ht    = $signed({1'b0, req.tx_height}) - $signed({1'b0, env_height});
    q_next.hr    = $signed({1'b0, req.rx_height}) - $signed({1'b0, env_height});
    q_next.dwl   = {{ump_pkg::WL_W{1'b0}}, req.distance}
                 * {{ump_pkg::DIST_W{1'b0}}, wavelength};
    q_next.hh    = q_next.ht * q_next.hr;
    q_next.below = (req.func == ump_pkg::FUNC_LOS) && (req.distance < min_distance);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule
`default_nettype wire

### rtl/ump_log10.sv
// Three-stage fixed-point log10(arg / 2^SHIFT) in Q16: leading one, table, scale.
// Depends on ump_pkg.
`default_nettype none
module ump_log10 #(
  parameter int N     = ump_pkg::LOG_TABLE_ENTRIES_DEF,
  parameter int W     = ump_pkg::DIST_W,
  parameter int SHIFT = 4
) (
  input  wire logic                              clk,
  input  wire logic [2:0]                        en,
  input  wire logic [W-1:0]                      arg,
  output logic signed [ump_pkg::LOG_W-1:0]       lg
);

  localparam int PW = $clog2(W);
  localparam int NW = $clog2(N + 1);
  localparam int IW = $clog2(N);
  localparam int LW = ump_pkg::LOG_W;

  logic [16:0] tab [N];

  for (genvar i = 0; i < N; i++) begin : g_tab
    localparam logic [63:0] X0 = ((64'(N) + 64'(i)) << 30) / 64'(N);
    assign tab[i] = ump_pkg::log_frac(X0);
  end

  logic [PW-1:0] p_next, p;
  logic [W:0]    sv;
  logic [W-1:0]  frac;

  always_comb begin
    p_next = '0;
    for (int i = 0; i < W; i++) begin
      if (arg[i]) p_next = PW'(i);
    end
    sv = {1'b0, arg} << (PW + 1)'(W - int'(p_next));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p    <= p_next;
      frac <= sv[W-1:0];
    end
  end

  logic [W+NW-1:0]      prod;
  logic [IW-1:0]        idx;
  logic signed [LW-1:0] l2_next, l2;

  always_comb begin
    prod    = {{NW{1'b0}}, frac} * {{W{1'b0}}, NW'(N)};
    idx     = prod[W+IW-1:W];
    l2_next = $signed({{(LW-PW-16){1'b0}}, p, 16'h0000})
            + $signed(LW'(tab[idx]))
            - $signed(LW'(SHIFT << 16));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      l2 <= l2_next;
    end
  end

  logic signed [LW+15:0] m, mr;

  always_comb begin
    m  = (LW + 16)'(l2) * (LW + 16)'(ump_pkg::LOG10_2);
    mr = m + (LW + 16)'(32768);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      lg <= mr[LW+15:16];
    end
  end

endmodule
`default_nettype wire

### rtl/ump_combine.sv
// Last three stages: law sums, NLOS slope product, final rounding and saturation.
// Depends on ump_pkg.
`default_nettype none
module ump_combine (
  input  wire logic                               clk,
  input  wire logic [2:0]                         en,
  input  wire ump_pkg::side_t                     side,
  input  wire logic signed [ump_pkg::LOG_W-1:0]   ld,
  input  wire logic signed [ump_pkg::LOG_W-1:0]   lf,
  input  wire logic signed [ump_pkg::LOG_W-1:0]   lh1,
  input  wire logic signed [ump_pkg::LOG_W-1:0]   lh2,
  output ump_pkg::rsp_t                           rsp
);

  localparam int AW = ump_pkg::ACC_W;
  localparam int LW = ump_pkg::LOG_W;
  localparam int IW = ump_pkg::INR_W;

  logic signed [AW-1:0] eld, elf, eh1, eh2;
  logic signed [AW-1:0] near_acc, far_acc, inner_raw, part_next;
  logic signed [LW-1:0] lf_adj;

  always_comb begin
    lf_adj    = lf - ump_pkg::LOG10_5000;
    eld       = AW'(ld);
    elf       = AW'(lf_adj);
    eh1       = AW'(lh1);
    eh2       = AW'(lh2);
    near_acc  = ump_pkg::C26 * eld + (ump_pkg::C39 <<< 16) + ump_pkg::C20 * elf;
    far_acc   = ump_pkg::C40 * eld + (ump_pkg::C1347 <<< 16)
              - ump_pkg::C14 * eh1 - ump_pkg::C14 * eh2 + ump_pkg::C6 * elf;
    inner_raw = (ump_pkg::C449 <<< 16) - ump_pkg::C655 * eh1 + AW'(128);
    part_next = (ump_pkg::C3446 <<< 16) + ump_pkg::C583 * eh1 + ump_pkg::C23 * elf;
  end

  logic signed [AW-1:0] los_e, part_e;
  logic signed [IW-1:0] inner_e;
  logic signed [LW-1:0] ld_e;
  ump_pkg::side_t       side_e, side_f;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      los_e   <= side.near ? near_acc : far_acc;
      inner_e <= inner_raw[IW+7:8];
      part_e  <= part_next;
      ld_e    <= ld;
      side_e  <= side;
    end
  end

  logic signed [IW+LW-1:0] m, mr;
  logic signed [AW-1:0]    nlos;

  always_comb begin
    m    = inner_e * ld_e;
    mr   = m + (IW + LW)'(128);
    nlos = AW'($signed(mr[IW+LW-1:8])) + part_e;
  end

  logic signed [AW-1:0] acc_f;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      acc_f  <= (side_e.func == ump_pkg::FUNC_NLOS) ? nlos : los_e;
      side_f <= side_e;
    end
  end

  logic signed [AW-1:0]    ar;
  logic signed [AW-17:0]   rq;
  ump_pkg::rsp_t           rsp_next;

  always_comb begin
    ar = acc_f + AW'(32768);
    rq = ar[AW-1:16];
    if (side_f.below) begin
      rsp_next.loss_db = '0;
      rsp_next.status  = ump_pkg::STATUS_BELOW_MIN;
    end else if (side_f.invalid) begin
      rsp_next.loss_db = ump_pkg::LOSS_MAX;
      rsp_next.status  = ump_pkg::STATUS_BAD_ARG;
    end else begin
      if (rq > (AW - 16)'(ump_pkg::LOSS_MAX)) begin
        rsp_next.loss_db = ump_pkg::LOSS_MAX;
      end else if (rq < (AW - 16)'(ump_pkg::LOSS_MIN)) begin
        rsp_next.loss_db = ump_pkg::LOSS_MIN;
      end else begin
        rsp_next.loss_db = rq[16:0];
      end
      rsp_next.status = ump_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire

### dv/urban_macro_path_loss_core_test.sv
// Testbench for urban_macro_path_loss_core: directed and random links under
// several register settings, checked against an in-bench path loss predictor.
// Depends on ump_pkg and the core RTL.
`default_nettype none
module urban_macro_path_loss_core_test;

  localparam int TAB_N = ump_pkg::LOG_TABLE_ENTRIES_DEF;
  localparam int DRAIN_CYCLES = 20;
  localparam int HW = ump_pkg::HGT_W;
  localparam int DW = ump_pkg::DIST_W;
  localparam int CW = ump_pkg::CFG_DATA_W;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  ump_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  ump_pkg::rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [ump_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  urban_macro_path_loss_core i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  longint unsigned log_frac_tab[TAB_N];
  logic [HW-1:0]               env_height_q = ump_pkg::RST_ENV_HEIGHT;
  logic [ump_pkg::WL_W-1:0]    wavelength_q = ump_pkg::RST_WAVELENGTH;
  logic [DW-1:0]               min_dist_q   = ump_pkg::RST_MIN_DISTANCE;
  logic [ump_pkg::CAR_W-1:0]   carrier_q    = ump_pkg::RST_CARRIER_MHZ;

  ump_pkg::rsp_t expected_loss_q[$];
  int mismatches = 0;
  int links_sent = 0;
  int results_seen = 0;
  int status_hits[4] = '{0, 0, 0, 0};
  bit no_idle = 1'b0;

  function automatic longint round_shift(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint log2_fix(longint unsigned v);
    int p;
    longint unsigned idx;
    p = 0;
    while (p < 62 && (v >> (p + 1)) != 0) p++;
    idx = ((v - (longint'(1) << p)) * TAB_N) >> p;
    if (idx >= TAB_N) idx = TAB_N - 1;
    return (longint'(p) << 16) + longint'(log_frac_tab[idx]);
  endfunction

  function automatic longint log10_fix(longint unsigned v, int sh);
    return round_shift((log2_fix(v) - (longint'(sh) << 16)) * 19728, 16);
  endfunction

  function automatic ump_pkg::rsp_t make_rsp(longint loss, logic [1:0] st);
    ump_pkg::rsp_t r;
    if (loss > 65535) loss = 65535;
    if (loss < -65536) loss = -65536;
    r.loss_db = loss[16:0];
    r.status = st;
    return r;
  endfunction

  function automatic ump_pkg::rsp_t predict_path_loss(ump_pkg::req_t r);
    longint tx, ht, hr, ld, lf, lht, lhr, acc, inner;
    longint unsigned span;
    bit near;
    tx = r.tx_height;
    span = r.distance;
    if (r.func == ump_pkg::FUNC_LOS) begin
      ht = longint'(r.tx_height) - longint'(env_height_q);
      hr = longint'(r.rx_height) - longint'(env_height_q);
      if (span < min_dist_q) return make_rsp(0, ump_pkg::STATUS_BELOW_MIN);
      near = longint'(span * wavelength_q) < ht * hr * 16384;
      if (span == 0 || carrier_q == 0 || (!near && (ht <= 0 || hr <= 0)))
        return make_rsp(65535, ump_pkg::STATUS_BAD_ARG);
      ld = log10_fix(span, 4);
      lf = log10_fix(carrier_q, 0) - 242416;
      if (near) acc = 6656 * ld + (longint'(9984) << 16) + 5120 * lf;
      else begin
        lht = log10_fix(ht, 4);
        lhr = log10_fix(hr, 4);
        acc = 10240 * ld + (longint'(3448) << 16) - 3584 * lht - 3584 * lhr + 1536 * lf;
      end
    end else begin
      if (span == 0 || carrier_q == 0 || tx <= 0)
        return make_rsp(65535, ump_pkg::STATUS_BAD_ARG);
      ld = log10_fix(span, 4);
      lf = log10_fix(carrier_q, 0) - 242416;
      lht = log10_fix(tx, 4);
      inner = round_shift((longint'(11494) << 16) - 1677 * lht, 8);
      acc = round_shift(inner * ld, 8) + (longint'(8822) << 16) + 1492 * lht + 5888 * lf;
    end
    return make_rsp(round_shift(acc, 16), ump_pkg::STATUS_OK);
  endfunction

  initial begin
    longint unsigned x, bits;
    for (int i = 0; i < TAB_N; i++) begin
      x = ((longint'(TAB_N) + i) << 30) / TAB_N;
      bits = 0;
      for (int k = 0; k < 17; k++) begin
        x = (x * x) >> 30;
        bits = bits << 1;
        if (x >= (64'd1 << 31)) begin
          bits = bits | 1;
          x = x >> 1;
        end
      end
      log_frac_tab[i] = (bits + 1) >> 1;
    end
  end

  // result side: random stalls and checking
  int stall_left = 0;
  always @(posedge clk) begin
    ump_pkg::rsp_t want;
    int nxt;
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_left = 0;
    end else begin
      nxt = stall_left;
      if (rsp_valid && rsp_ready) begin
        results_seen++;
        if (expected_loss_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result loss=%0d status=%0d",
                                         rsp.loss_db, rsp.status);
        end else begin
          want = expected_loss_q.pop_front();
          status_hits[want.status]++;
          if (rsp.loss_db !== want.loss_db || rsp.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected loss=%0d status=%0d, got loss=%0d status=%0d",
                       want.loss_db, want.status, rsp.loss_db, rsp.status);
          end
        end
        nxt = no_idle ? 0 : $urandom_range(0, 3);
      end else if (nxt > 0) nxt--;
      stall_left = nxt;
      rsp_ready <= (nxt == 0);
    end
  end

  task automatic send_link(ump_pkg::req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    expected_loss_q.push_back(predict_path_loss(r));
    links_sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_loss_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [ump_pkg::CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ump_pkg::REG_ENV_HEIGHT:   env_height_q = val[HW-1:0];
      ump_pkg::REG_WAVELENGTH:   wavelength_q = val[ump_pkg::WL_W-1:0];
      ump_pkg::REG_MIN_DISTANCE: min_dist_q   = val[DW-1:0];
      ump_pkg::REG_CARRIER_MHZ:  carrier_q    = val[ump_pkg::CAR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int env, int wl, int mind, int car);
    write_reg(ump_pkg::REG_ENV_HEIGHT, CW'(env));
    write_reg(ump_pkg::REG_WAVELENGTH, CW'(wl));
    write_reg(ump_pkg::REG_MIN_DISTANCE, CW'(mind));
    write_reg(ump_pkg::REG_CARRIER_MHZ, CW'(car));
  endtask

  function automatic ump_pkg::req_t link(logic f, int tx, int rx, int d);
    ump_pkg::req_t r;
    r.func = f;
    r.tx_height = HW'(tx);
    r.rx_height = HW'(rx);
    r.distance = DW'(d);
    return r;
  endfunction

  function automatic ump_pkg::req_t random_link();
    ump_pkg::req_t r;
    r = ($bits(ump_pkg::req_t))'({$urandom, $urandom});
    r.func = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: r.distance = DW'($urandom_range(0, 64));
      1: r.distance = DW'($urandom_range(0, 4096));
      2: r.distance = DW'($urandom_range(0, 65536));
      default: r.distance = DW'($urandom);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      r.tx_height = HW'(int'(env_height_q) + int'($urandom_range(0, 40)) - 8);
      r.rx_height = HW'(int'(env_height_q) + int'($urandom_range(0, 40)) - 8);
    end
    if ($urandom_range(0, 40) == 0) r.tx_height = '0;
    return r;
  endfunction

  task automatic test_los_defaults();
    send_link(link(ump_pkg::FUNC_LOS, 400, 24, 0));
    send_link(link(ump_pkg::FUNC_LOS, 400, 24, 15));
    send_link(link(ump_pkg::FUNC_LOS, 400, 24, 16));
    send_link(link(ump_pkg::FUNC_LOS, 400, 24, 1600));
    send_link(link(ump_pkg::FUNC_LOS, 400, 24, 1048575));
    send_link(link(ump_pkg::FUNC_LOS, 4095, 4095, 1048575));
    send_link(link(ump_pkg::FUNC_LOS, 0, 24, 800000));
    send_link(link(ump_pkg::FUNC_LOS, 1, 1, 16));
    drain();
  endtask

  task automatic test_nlos_defaults();
    send_link(link(ump_pkg::FUNC_NLOS, 0, 100, 5000));
    send_link(link(ump_pkg::FUNC_NLOS, 400, 0, 0));
    send_link(link(ump_pkg::FUNC_NLOS, 1, 4095, 1));
    send_link(link(ump_pkg::FUNC_NLOS, 4095, 0, 1048575));
    send_link(link(ump_pkg::FUNC_NLOS, 400, 24, 16000));
    drain();
  endtask

  task automatic test_reg_extremes();
    set_regs(4095, 1, 0, 10000);
    send_link(link(ump_pkg::FUNC_LOS, 4095, 4095, 0));
    send_link(link(ump_pkg::FUNC_LOS, 100, 100, 5000));
    send_link(link(ump_pkg::FUNC_NLOS, 4095, 0, 1));
    drain();
    set_regs(200, 65535, 1048575, 100);
    send_link(link(ump_pkg::FUNC_LOS, 4095, 4095, 1048574));
    send_link(link(ump_pkg::FUNC_LOS, 4095, 4095, 1048575));
    send_link(link(ump_pkg::FUNC_NLOS, 300, 4095, 1048575));
    drain();
    set_regs(0, 0, 0, 0);
    send_link(link(ump_pkg::FUNC_LOS, 300, 300, 100));
    send_link(link(ump_pkg::FUNC_NLOS, 300, 300, 100));
    drain();
    set_regs(10, 0, 1, 16383);
    send_link(link(ump_pkg::FUNC_LOS, 300, 300, 100));
    send_link(link(ump_pkg::FUNC_LOS, 5, 300, 100));
    send_link(link(ump_pkg::FUNC_LOS, 5, 5, 100));
    drain();
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n == count / 2) begin
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_loss_q.size() != 0) @(posedge clk);
      end
      send_link(random_link());
    end
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_random_configs();
    set_regs(ump_pkg::RST_ENV_HEIGHT, ump_pkg::RST_WAVELENGTH,
             ump_pkg::RST_MIN_DISTANCE, ump_pkg::RST_CARRIER_MHZ);
    test_random(260);
    set_regs(160, 1500, 64, 2000);
    test_random(260);
    for (int p = 0; p < 3; p++) begin
      set_regs($urandom_range(0, 4095), $urandom_range(1, 65535),
               $urandom_range(0, 2000), $urandom_range(100, 10000));
      test_random(260);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_los_defaults();
    test_nlos_defaults();
    test_reg_extremes();
    test_random_configs();
    $display("covered %0d links: %0d computed, %0d below minimum, %0d invalid argument",
             links_sent, status_hits[0], status_hits[1], status_hits[2]);
    $display("register settings included all extremes; %0d results checked", results_seen);
    if (mismatches == 0 && expected_loss_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
rtl/ump_pkg.sv
rtl/ump_front.sv
rtl/ump_log10.sv
rtl/ump_combine.sv
rtl/urban_macro_path_loss_core.sv
dv/urban_macro_path_loss_core_test.sv
